// ----- hdl/gsp_pkg.sv -----
package gsp_pkg;

	// Store geometry and number format
	localparam int STORE_DEPTH = 256;
	localparam int COORD_W     = 16;

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int SQ_W  = 2 * COORD_W;
	localparam int R2_W  = 2 * COORD_W;
	localparam int SUM_W = SQ_W + 2;

	// Fixed field widths on the ports
	localparam int FIELD_W   = 16;
	localparam int CFG_W     = 9;
	localparam int SLOT_W    = 8;
	localparam int COUNT_W   = 9;
	localparam int IN_W      = 4 * FIELD_W;
	localparam int OUT_W     = 24;
	localparam int OUT_PAD_W = OUT_W - (1 + SLOT_W + 1 + COUNT_W);
	localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(256);

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} pt_t;

	// One stored sphere: center and squared radius
	typedef struct packed {
		pt_t             pt;
		logic [R2_W-1:0] r2;
	} entry_t;

	// Candidate token handed from cell to cell. The squared terms and r2
	// belong to the previous cell; the next hop folds them into cov.
	typedef struct packed {
		pt_t              pt;
		logic [CNT_W-1:0] rem;
		logic             cov;
		logic             live;
		logic [SQ_W-1:0]  sx;
		logic [SQ_W-1:0]  sy;
		logic [SQ_W-1:0]  sz;
		logic [R2_W-1:0]  r2;
	} tok_t;

	function automatic logic fold(input tok_t t);
		logic [SUM_W-1:0] d2;
		d2 = SUM_W'(t.sx) + SUM_W'(t.sy) + SUM_W'(t.sz);
		return t.cov | (t.live && (d2 < SUM_W'(t.r2)));
	endfunction

endpackage

// ----- hdl/gsp_cell.sv -----
module gsp_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  gsp_pkg::entry_t wr,
	input  logic            vld_in,
	input  gsp_pkg::tok_t   tin,
	output logic            vld_out,
	output gsp_pkg::tok_t   tout
);

	gsp_pkg::entry_t ent_q;
	gsp_pkg::tok_t   tok_q;
	gsp_pkg::tok_t   tok_nx;
	logic            vld_q;
	logic            live;
	logic [gsp_pkg::COORD_W-1:0] dx, dy, dz;

	always_comb begin
		live = vld_in && (tin.rem != '0);
		dx = (tin.pt.x >= ent_q.pt.x) ? tin.pt.x - ent_q.pt.x : ent_q.pt.x - tin.pt.x;
		dy = (tin.pt.y >= ent_q.pt.y) ? tin.pt.y - ent_q.pt.y : ent_q.pt.y - tin.pt.y;
		dz = (tin.pt.z >= ent_q.pt.z) ? tin.pt.z - ent_q.pt.z : ent_q.pt.z - tin.pt.z;
		tok_nx.pt   = tin.pt;
		tok_nx.rem  = live ? tin.rem - gsp_pkg::CNT_W'(1) : '0;
		tok_nx.cov  = gsp_pkg::fold(tin);
		tok_nx.live = live;
		tok_nx.sx   = gsp_pkg::SQ_W'(dx) * gsp_pkg::SQ_W'(dx);
		tok_nx.sy   = gsp_pkg::SQ_W'(dy) * gsp_pkg::SQ_W'(dy);
		tok_nx.sz   = gsp_pkg::SQ_W'(dz) * gsp_pkg::SQ_W'(dz);
		tok_nx.r2   = ent_q.r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
		if (we) begin
			ent_q <= wr;
		end
	end

	assign vld_out = vld_q;
	assign tout    = tok_q;

endmodule

// ----- hdl/gsp_chain.sv -----
module gsp_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [gsp_pkg::IDX_W-1:0]  wr_idx,
	input  gsp_pkg::entry_t            wr,
	input  logic                       head_vld,
	input  gsp_pkg::tok_t              head,
	output logic                       tail_vld,
	output gsp_pkg::tok_t              tail
);

	logic          vld_link [gsp_pkg::STORE_DEPTH+1];
	gsp_pkg::tok_t tok_link [gsp_pkg::STORE_DEPTH+1];

	assign vld_link[0] = head_vld;
	assign tok_link[0] = head;

	for (genvar k = 0; k < gsp_pkg::STORE_DEPTH; k++) begin : g_cell
		gsp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.we      (we && (wr_idx == gsp_pkg::IDX_W'(k))),
			.wr      (wr),
			.vld_in  (vld_link[k]),
			.tin     (tok_link[k]),
			.vld_out (vld_link[k+1]),
			.tout    (tok_link[k+1])
		);
	end

	assign tail_vld = vld_link[gsp_pkg::STORE_DEPTH];
	assign tail     = tok_link[gsp_pkg::STORE_DEPTH];

endmodule

// ----- hdl/greedy_sphere_packing.sv -----
// Greedy sphere packing (non-maximum suppression of spheres). Each candidate
// on the input stream is checked against every sphere stored so far and is
// stored unless its center lies strictly inside one of them; once the store
// holds max_spheres entries (capped at the store depth) candidates are only
// reported, not stored, until a candidate with restart set empties the store.
// Spheres live in a row of STORE_DEPTH cells, one sphere per cell; the
// candidate walks the row one cell per clock and each cell squares the
// center differences against its own sphere. A candidate that gets checked
// therefore stays in the scan until it has passed through every cell of the
// row, so its scan time is set by the length of the cell row, whatever the
// fill of the store; a candidate that meets a full store skips the scan and
// goes straight to the finish state. The result is registered, and the next
// candidate may be taken while it waits on the output; the block does not
// finish a candidate while the previous result still waits.
module greedy_sphere_packing (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gsp_pkg::CFG_W-1:0]   cfg_data,    // max_spheres
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [gsp_pkg::IN_W-1:0]    s_tdata,     // center_x, center_y, center_z, radius
	input  logic                        s_tuser,     // restart
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gsp_pkg::OUT_W-1:0]   m_tdata      // accepted, slot, full_res, count, zero pad
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                    state_q;
	logic [gsp_pkg::CFG_W-1:0]     max_q;
	logic [gsp_pkg::CNT_W-1:0]     count_q;
	gsp_pkg::pt_t                  cand_q;
	logic [gsp_pkg::R2_W-1:0]      r2_q;
	logic                          full_q;
	logic                          cov_q;
	logic                          inj_q;
	logic                          m_tvalid_q;
	logic [gsp_pkg::OUT_W-1:0]     m_tdata_q;

	logic                          s_fire;
	logic                          fin_fire;
	logic                          took;
	logic [gsp_pkg::CNT_W-1:0]     cnt_start;
	logic [gsp_pkg::CNT_W-1:0]     cnt_after;
	logic [gsp_pkg::CMP_W-1:0]     lim;
	logic [gsp_pkg::COORD_W-1:0]   in_r;
	gsp_pkg::pt_t                  in_pt;
	gsp_pkg::tok_t                 head;
	gsp_pkg::tok_t                 tail;
	logic                          tail_vld;
	gsp_pkg::entry_t               wr;

	// Effective limit: the smaller of the register and the store depth
	assign lim = (gsp_pkg::CMP_W'(max_q) > gsp_pkg::CMP_W'(gsp_pkg::STORE_DEPTH))
		? gsp_pkg::CMP_W'(gsp_pkg::STORE_DEPTH) : gsp_pkg::CMP_W'(max_q);

	// Coordinates keep only their low COORD_W bits
	assign in_pt.x = gsp_pkg::COORD_W'(s_tdata[15:0]);
	assign in_pt.y = gsp_pkg::COORD_W'(s_tdata[31:16]);
	assign in_pt.z = gsp_pkg::COORD_W'(s_tdata[47:32]);
	assign in_r    = gsp_pkg::COORD_W'(s_tdata[63:48]);

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cnt_start = s_tuser ? '0 : count_q;

	// Finish once the output register is free; store unless covered or full
	assign fin_fire  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	assign took      = !full_q && !cov_q;
	assign cnt_after = count_q + gsp_pkg::CNT_W'(took);

	// Head of the row: no folded terms yet, rem carries the live entry count
	always_comb begin
		head      = '0;
		head.pt   = cand_q;
		head.rem  = count_q;
	end

	assign wr.pt = cand_q;
	assign wr.r2 = r2_q;

	gsp_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (fin_fire && took),
		.wr_idx   (count_q[gsp_pkg::IDX_W-1:0]),
		.wr       (wr),
		.head_vld (inj_q),
		.head     (head),
		.tail_vld (tail_vld),
		.tail     (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_q      <= gsp_pkg::MAX_RESET;
			count_q    <= '0;
			inj_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			// launch into the row only when the store has room
			inj_q <= s_fire && (gsp_pkg::CMP_W'(cnt_start) < lim);
			if (fin_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						count_q <= cnt_start;
						// skip the scan when the store is already full
						if (gsp_pkg::CMP_W'(cnt_start) >= lim) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (tail_vld) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						count_q <= cnt_after;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: candidate, squared radius, verdict and result word
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cand_q <= in_pt;
			r2_q   <= gsp_pkg::R2_W'(in_r) * gsp_pkg::R2_W'(in_r);
			full_q <= (gsp_pkg::CMP_W'(cnt_start) >= lim);
			cov_q  <= 1'b0;
		end else if ((state_q == ST_SCAN) && tail_vld) begin
			cov_q <= gsp_pkg::fold(tail);
		end
		if (fin_fire) begin
			m_tdata_q <= {gsp_pkg::OUT_PAD_W'(0),
				gsp_pkg::COUNT_W'(cnt_after),
				(gsp_pkg::CMP_W'(cnt_after) >= lim),
				took ? gsp_pkg::SLOT_W'(count_q) : gsp_pkg::SLOT_W'(0),
				took};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		gsp_pkg::CMP_W'(count_q) <= gsp_pkg::CMP_W'(gsp_pkg::STORE_DEPTH))
		else $error("stored count beyond store depth");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |-> (state_q == ST_SCAN))
		else $error("candidate left the cell row outside a scan");

	a_store_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && took) |=> (count_q == $past(count_q) + gsp_pkg::CNT_W'(1)))
		else $error("stored count did not advance on a store");

	a_no_store_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && took) |-> (gsp_pkg::CMP_W'(count_q) < lim))
		else $error("sphere stored into a full store");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling: even the most candidates the phases may send (under
	// 7000), each with a full scan and the longest gaps on both sides, stay
	// well below it.
	localparam int CYCLE_LIMIT = 10_000_000;

	// Room for verdicts in flight; the block never holds more than two
	localparam int VQ_DEPTH = 64;

	// One result word as it sits in the low bits of m_tdata
	typedef struct packed {
		logic [gsp_pkg::COUNT_W-1:0] count;
		logic                        full;
		logic [gsp_pkg::SLOT_W-1:0]  slot;
		logic                        accepted;
	} verdict_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [gsp_pkg::CFG_W-1:0]   cfg_data;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [gsp_pkg::IN_W-1:0]    s_tdata;
	logic                        s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [gsp_pkg::OUT_W-1:0]   m_tdata;

	greedy_sphere_packing uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the sphere store, kept by the predictor
	int unsigned sph_x   [gsp_pkg::STORE_DEPTH];
	int unsigned sph_y   [gsp_pkg::STORE_DEPTH];
	int unsigned sph_z   [gsp_pkg::STORE_DEPTH];
	int unsigned sph_rad [gsp_pkg::STORE_DEPTH];
	int unsigned stored_count = 0;
	int unsigned limit_reg    = gsp_pkg::MAX_RESET;

	// Ring of verdicts waiting for their result transfer
	verdict_t    expected_verdicts [VQ_DEPTH];
	int unsigned vq_head = 0;
	int unsigned vq_tail = 0;

	bit          gaps_on      = 1'b1;
	bit          last_checked;
	int unsigned hold_cycles  = 0;
	int unsigned cycle_count  = 0;
	int unsigned n_errors     = 0;
	int unsigned n_results    = 0;
	int unsigned n_checked    = 0;
	int unsigned n_accepted   = 0;
	int unsigned n_ignored    = 0;
	int unsigned n_restarts   = 0;

	function automatic int unsigned verdicts_pending();
		return vq_tail - vq_head;
	endfunction

	function automatic void stash_verdict(input verdict_t v);
		if (verdicts_pending() >= VQ_DEPTH) begin
			$error("more than %0d verdicts in flight", VQ_DEPTH);
			n_errors++;
		end
		expected_verdicts[vq_tail % VQ_DEPTH] = v;
		vq_tail++;
	endfunction

	function automatic verdict_t oldest_verdict();
		verdict_t v;
		v = expected_verdicts[vq_head % VQ_DEPTH];
		vq_head++;
		return v;
	endfunction

	function automatic int unsigned effective_limit();
		return (limit_reg > gsp_pkg::STORE_DEPTH) ? gsp_pkg::STORE_DEPTH : limit_reg;
	endfunction

	// Work out the verdict for one candidate, update the shadow store and
	// queue the verdict. Return 1 when the candidate was scanned, 0 when a
	// full store made the block ignore it.
	function automatic bit judge_candidate(input bit restart,
			input logic [gsp_pkg::FIELD_W-1:0] x, y, z, r);
		verdict_t          v;
		int unsigned       limit;
		longint unsigned   dx, dy, dz, d2, r2;
		bit                covered;
		bit                scanned;
		limit   = effective_limit();
		v       = '0;
		covered = 1'b0;
		scanned = 1'b0;
		if (restart) begin
			stored_count = 0;
			n_restarts++;
		end
		if (stored_count < limit) begin
			scanned = 1'b1;
			for (int k = 0; k < stored_count && !covered; k++) begin
				dx = (sph_x[k] >= x) ? sph_x[k] - x : x - sph_x[k];
				dy = (sph_y[k] >= y) ? sph_y[k] - y : y - sph_y[k];
				dz = (sph_z[k] >= z) ? sph_z[k] - z : z - sph_z[k];
				d2 = dx * dx + dy * dy + dz * dz;
				r2 = longint'(sph_rad[k]) * longint'(sph_rad[k]);
				// strictly inside rejects; touching the surface does not
				if (d2 < r2)
					covered = 1'b1;
			end
			if (!covered) begin
				sph_x[stored_count]   = x;
				sph_y[stored_count]   = y;
				sph_z[stored_count]   = z;
				sph_rad[stored_count] = r;
				v.accepted = 1'b1;
				v.slot     = gsp_pkg::SLOT_W'(stored_count);
				stored_count++;
				n_accepted++;
			end
			n_checked++;
		end else begin
			n_ignored++;
		end
		v.full  = (stored_count >= limit);
		v.count = gsp_pkg::COUNT_W'(stored_count);
		stash_verdict(v);
		return scanned;
	endfunction

	function automatic logic [gsp_pkg::FIELD_W-1:0] clamp_coord(input int value);
		if (value < 0)
			return '0;
		if (value > 65535)
			return '1;
		return gsp_pkg::FIELD_W'(value);
	endfunction

	// Drive one candidate and hold it until the block takes the transfer.
	// Valid stays high afterwards so back-to-back candidates never glitch it.
	task automatic send_candidate(input bit restart,
			input logic [gsp_pkg::FIELD_W-1:0] x, y, z, r);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= restart;
		s_tdata  <= {r, z, y, x};
		do @(posedge clk); while (s_tready !== 1'b1);
		last_checked = judge_candidate(restart, x, y, z, r);
	endtask

	// Drop valid and hold until every queued verdict has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdicts_pending() != 0)
			@(posedge clk);
	endtask

	// Write max_spheres; only ever done with the block idle
	task automatic write_limit(input int unsigned value);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= gsp_pkg::CFG_W'(value);
		@(posedge clk);
		cfg_we   <= 1'b0;
		limit_reg = value;
	endtask

	// Corners of the cube, full-size radii and the one-step-inside neighbor
	task automatic test_field_extremes();
		send_candidate(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_candidate(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_candidate(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_candidate(1'b0, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000);
	endtask

	// Distance exactly equal to the radius passes, one less is rejected
	task automatic test_surface_contact();
		send_candidate(1'b1, 16'd32768, 16'd32768, 16'd32768, 16'd1000);
		send_candidate(1'b0, 16'd33768, 16'd32768, 16'd32768, 16'd900);
		send_candidate(1'b0, 16'd32768, 16'd33767, 16'd32768, 16'd800);
		send_candidate(1'b0, 16'd32768, 16'd32768, 16'd31769, 16'd700);
		send_candidate(1'b0, 16'd32768, 16'd32768, 16'd31768, 16'd600);
	endtask

	// Zero-radius spheres never cover anything; a larger radius arriving out
	// of order still covers what follows it
	task automatic test_zero_radius_unsorted();
		send_candidate(1'b1, 16'd100, 16'd100, 16'd100, 16'd0);
		send_candidate(1'b0, 16'd100, 16'd100, 16'd100, 16'd0);
		send_candidate(1'b0, 16'd100, 16'd100, 16'd100, 16'd5000);
		send_candidate(1'b0, 16'd101, 16'd100, 16'd100, 16'd10);
	endtask

	// Tiny limit, limit lowered under the fill, zero limit, limit above depth
	task automatic test_limit_edges();
		write_limit(2);
		send_candidate(1'b1, 16'd1000,  16'd1000,  16'd1000,  16'd50);
		send_candidate(1'b0, 16'd30000, 16'd30000, 16'd30000, 16'd40);
		send_candidate(1'b0, 16'd60000, 16'd60000, 16'd60000, 16'd30);
		write_limit(1);
		send_candidate(1'b0, 16'd5000,  16'd5000,  16'd5000,  16'd20);
		send_candidate(1'b1, 16'd5000,  16'd5000,  16'd5000,  16'd20);
		write_limit(0);
		send_candidate(1'b1, 16'd7000,  16'd7000,  16'd7000,  16'd20);
		write_limit(511);
		send_candidate(1'b1, 16'd9000,  16'd9000,  16'd9000,  16'd20);
		send_candidate(1'b0, 16'd9000,  16'd9000,  16'd9000,  16'd10);
	endtask

	// One phase of random packing at a given limit. Runs of candidates come
	// with decreasing radii; a share of centers is placed on or near the
	// surface of a stored sphere so rejections and touching cases show up.
	task automatic run_packing_phase(input int unsigned limit_value, input int target,
			input int max_items, input int unsigned radius_top,
			input int unsigned restart_per_mille);
		int                          scanned_here;
		int                          sent;
		int unsigned                 cur_r;
		int unsigned                 k;
		int unsigned                 rk;
		int                          off;
		int                          axis;
		int                          cx, cy, cz;
		bit                          restart;
		logic [gsp_pkg::FIELD_W-1:0] x, y, z, r;
		write_limit(limit_value);
		scanned_here = 0;
		sent         = 0;
		cur_r        = radius_top;
		while (scanned_here < target && sent < max_items) begin
			// a full store only gets out of the way with a restart
			if (stored_count >= effective_limit())
				restart = ($urandom_range(0, 1) == 1);
			else
				restart = ($urandom_range(0, 999) < restart_per_mille);
			if (restart)
				cur_r = $urandom_range(radius_top / 2, radius_top);

			if ($urandom_range(0, 19) == 0) begin
				r = gsp_pkg::FIELD_W'($urandom_range(0, radius_top));
			end else begin
				if (cur_r > 0)
					cur_r -= $urandom_range(0, cur_r / 64 + 1);
				r = gsp_pkg::FIELD_W'(cur_r);
			end

			if (!restart && stored_count > 0 && $urandom_range(0, 9) < 4) begin
				k  = $urandom_range(0, stored_count - 1);
				rk = sph_rad[k];
				cx = sph_x[k];
				cy = sph_y[k];
				cz = sph_z[k];
				if ($urandom_range(0, 1) == 1) begin
					// one radius away along one axis, give or take one step
					off  = int'(rk) + int'($urandom_range(0, 2)) - 1;
					off  = ($urandom_range(0, 1) == 1) ? off : -off;
					axis = $urandom_range(0, 2);
					if (axis == 0)
						cx += off;
					else if (axis == 1)
						cy += off;
					else
						cz += off;
				end else begin
					cx += int'($urandom_range(0, 2 * rk)) - int'(rk);
					cy += int'($urandom_range(0, 2 * rk)) - int'(rk);
					cz += int'($urandom_range(0, 2 * rk)) - int'(rk);
				end
				x = clamp_coord(cx);
				y = clamp_coord(cy);
				z = clamp_coord(cz);
			end else begin
				x = gsp_pkg::FIELD_W'($urandom_range(0, 65535));
				y = gsp_pkg::FIELD_W'($urandom_range(0, 65535));
				z = gsp_pkg::FIELD_W'($urandom_range(0, 65535));
			end

			send_candidate(restart, x, y, z, r);
			if (last_checked)
				scanned_here++;
			sent++;
		end
	endtask

	task automatic test_random_packing();
		run_packing_phase(256, 200, 600, 30000, 15);
		// limit above the store depth; small radii so the store fills up
		run_packing_phase(511, 300, 900, 1500, 0);
		run_packing_phase(1,    60, 400, 65535, 50);
		// nothing is ever scanned here, so the item cap ends the phase
		run_packing_phase(0,     1,  20, 65535, 100);
		run_packing_phase(17,  150, 600, 20000, 20);
		run_packing_phase(255, 300, 900, 3000, 0);
		run_packing_phase(2,    60, 400, 40000, 50);
		run_packing_phase(100, 200, 700, 8000, 10);
		// lowered below the current fill: ignored until a restart
		run_packing_phase(40,  100, 500, 8000, 10);
		// last stretch without any idling on either side
		gaps_on = 1'b0;
		run_packing_phase(256, 250, 800, 65535, 10);
	endtask

	// Stimulus, in order
	initial begin
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		s_tdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_surface_contact();
		test_zero_radius_unsorted();
		test_limit_edges();
		test_random_packing();

		wait_idle();
		repeat (8) @(posedge clk);

		$display("Covered %0d candidates: %0d scanned, %0d stored, %0d ignored on a full store,",
			n_checked + n_ignored, n_checked, n_accepted, n_ignored);
		$display("%0d restarts, %0d verdicts compared, %0d mismatches",
			n_restarts, n_results, n_errors);
		if (n_errors == 0 && verdicts_pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: compare every transfer against the oldest verdict, then
	// pick the ready level for the next cycle (random stall bursts)
	initial begin
		verdict_t want;
		verdict_t got;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = verdict_t'(m_tdata[$bits(verdict_t)-1:0]);
				n_results++;
				if (verdicts_pending() == 0) begin
					$error("result with no candidate pending: %h", m_tdata);
					n_errors++;
				end else begin
					want = oldest_verdict();
					if (got.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
						n_errors++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got.slot);
						n_errors++;
					end
					if (got.full !== want.full) begin
						$error("full_res: expected %0d, got %0d", want.full, got.full);
						n_errors++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got.count);
						n_errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				hold_cycles = $urandom_range(1, 10) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
